>>> src/tst_pkg.sv
// package for the typed slot table: request/response structs and codes
// no dependencies
package tst_pkg;
   localparam int unsigned SLOT_W = 5;
   localparam int unsigned FIELD_W = 16;

   // slot count is tied to the slot field widths below
   localparam int unsigned MAX_SLOTS = 32;

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_PAIR  = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_CHECK = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_TOO_MANY = 2'd3;

   localparam logic [2:0] REG_FIRST  = 3'd0;
   localparam logic [2:0] REG_SECOND = 3'd1;
   localparam logic [2:0] REG_THIRD  = 3'd2;
   localparam logic [2:0] REG_IDW    = 3'd3;
   localparam logic [2:0] REG_CDW    = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [1:0]  slot_type;
      logic [4:0]  slot_index;
      logic [15:0] msg_id;
      logic [15:0] msg_cd;
      logic        last_pair;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] granted_slot;
      logic       match;
   } rsp_type;

   // configuration as seen by the back end
   typedef struct packed {
      logic [5:0]  first_count;
      logic [5:0]  second_count;
      logic [5:0]  third_count;
      logic [15:0] id_wildcard;
      logic [15:0] cd_wildcard;
   } cfg_type;
endpackage

>>> src/typed_slot_table_with_wildcard_filter_core.sv
// top level of the typed slot table with wildcard filter
// depends on tst_pkg, tst_csr, tst_front, tst_back, tst_ram
//
// Usage: a request is taken when start is high and busy is low.
// The front end holds up to two requests; the back end works through them
// one at a time and gives one response per request on rsp_*, marked by
// rsp_strobe for a single cycle. The receiver cannot stall responses.
// Free, filter pair, clear and invalid requests are answered from the idle
// state; alloc scans slots one per cycle; check reads the pair ram with a
// read, wait and compare step for each stored pair, through the single
// read port of the pair ram.
// Throughput: short requests leave the back end at one per cycle; alloc
// and check hold it for their whole scan, while the queue keeps filling.
// Reset clears all slot, length, bank and load state at once; the pair
// ram is not cleared since only written pairs are ever read.
// Configuration is written through the apb-style p* port, one register per word.
module typed_slot_table_with_wildcard_filter_core #(
   parameter int unsigned MAX_PAIRS = 16,
   parameter int unsigned ID_BITS   = 16,
   parameter int unsigned CD_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tst_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output tst_pkg::rsp_type rsp_payload,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   tst_pkg::cfg_type cfg;
   tst_pkg::req_type q_head;
   logic q_valid, pop;

   tst_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   tst_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_in(req_payload), .busy(busy),
      .pop(pop), .q_valid(q_valid), .q_head(q_head)
   );

   tst_back #(
      .MAX_PAIRS(MAX_PAIRS), .ID_BITS(ID_BITS), .CD_BITS(CD_BITS)
   ) u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_valid(q_valid), .q_head(q_head),
      .pop(pop), .rsp_valid(rsp_strobe), .rsp(rsp_payload)
   );
endmodule

>>> src/tst_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module tst_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

>>> src/tst_front.sv
// front end: takes requests into a two-entry queue
// depends on tst_pkg
module tst_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  tst_pkg::req_type req_in,
   output logic             busy,
   input  logic             pop,
   output logic             q_valid,
   output tst_pkg::req_type q_head
);
   tst_pkg::req_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push;

   assign busy    = cnt_ff == 2'd2;
   assign push    = start && !busy;
   assign q_valid = cnt_ff != 2'd0;
   assign q_head  = buf_ff[rd_ff];

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= req_in;
      end
   end
endmodule

>>> src/tst_back.sv
// back end: slot state, filter loads and pair scan over the pair ram
// depends on tst_pkg and tst_ram
module tst_back #(
   parameter int unsigned MAX_PAIRS = 16,
   parameter int unsigned ID_BITS   = 16,
   parameter int unsigned CD_BITS   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  tst_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  tst_pkg::req_type q_head,
   output logic             pop,
   output logic             rsp_valid,
   output tst_pkg::rsp_type rsp
);
   localparam int unsigned MAX_SLOTS = tst_pkg::MAX_SLOTS;
   localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int unsigned PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int unsigned LW = $clog2(MAX_PAIRS + 1);
   localparam int unsigned AW = SW + 1 + PW;
   localparam int unsigned DEPTH = MAX_SLOTS * 2 * (1 << PW);
   localparam int unsigned XW = 10; // wide enough for bounds up to 3*63

   typedef enum logic [2:0] {
      S_IDLE, S_ALLOC, S_READ, S_WAIT, S_CMP, S_DONE
   } state_type;

   state_type state_ff;
   logic [MAX_SLOTS-1:0] busy_ff, bank_ff;
   logic [LW-1:0] flen_ff [MAX_SLOTS];
   logic [LW-1:0] lcount_ff;
   logic [1:0]    lerr_ff;
   logic [SW-1:0] lslot_ff;
   logic          lon_ff;
   logic [SW:0]   scan_ff;
   logic [LW-1:0] k_ff;
   tst_pkg::req_type cur_ff;
   tst_pkg::rsp_type rsp_ff;
   logic          rsp_valid_ff;

   // masked operands
   logic [15:0] id_m, cd_m, idw_m, cdw_m;
   assign id_m  = q_head.msg_id & 16'((33'd1 << ID_BITS) - 33'd1);
   assign cd_m  = q_head.msg_cd & 16'((33'd1 << CD_BITS) - 33'd1);
   assign idw_m = cfg.id_wildcard & 16'((33'd1 << ID_BITS) - 33'd1);
   assign cdw_m = cfg.cd_wildcard & 16'((33'd1 << CD_BITS) - 33'd1);

   logic [XW-1:0] e0, e1, e2;
   assign e0 = XW'(cfg.first_count);
   assign e1 = e0 + XW'(cfg.second_count);
   assign e2 = e1 + XW'(cfg.third_count);

   function automatic logic [1:0] type_of(input logic [XW-1:0] s, input logic [XW-1:0] a,
                                          input logic [XW-1:0] b, input logic [XW-1:0] c);
      logic [1:0] t;
      if (s < a) t = 2'd0;
      else if (s < b) t = 2'd1;
      else if (s < c) t = 2'd2;
      else t = 2'd3;
      return t;
   endfunction

   // decode of the queue head
   logic          slot_ok, filt_ok;
   logic [SW-1:0] s;
   assign slot_ok = 32'(q_head.slot_index) < MAX_SLOTS;
   assign s       = SW'(q_head.slot_index);
   assign filt_ok = slot_ok && busy_ff[s] &&
                    type_of(XW'(q_head.slot_index), e0, e1, e2) == 2'd1;

   // alloc scan slot type
   logic [1:0] scan_type;
   logic [SW-1:0] scan_s;
   assign scan_s    = scan_ff[SW-1:0];
   assign scan_type = type_of(XW'(scan_ff), e0, e1, e2);

   // pair ram
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   rd_data;
   logic [SW-1:0] cs;
   assign cs = SW'(cur_ff.slot_index);
   assign wr_en   = (state_ff == S_IDLE) && q_valid && q_head.op == tst_pkg::OP_PAIR && filt_ok
                    && !(id_m > idw_m || cd_m > cdw_m)
                    && (lon_ff && lslot_ff == s ? lcount_ff : '0) < LW'(MAX_PAIRS);
   assign wr_addr = {s, !bank_ff[s], PW'(lon_ff && lslot_ff == s ? lcount_ff : '0)};
   assign rd_addr = {cs, bank_ff[cs], PW'(k_ff)};

   tst_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data({id_m, cd_m}), .rd_addr(rd_addr), .rd_data(rd_data)
   );

   logic hit;
   assign hit = (rd_data[31:16] == cur_ff.msg_id || rd_data[31:16] == idw_m) &&
                (rd_data[15:0] == cur_ff.msg_cd || rd_data[15:0] == cdw_m);

   assign pop       = (state_ff == S_IDLE) && q_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // sequencer
   always_ff @(posedge clock) begin
      logic [LW-1:0] lc;
      logic [1:0]    le;
      logic [1:0]    st;
      logic          rv;
      tst_pkg::rsp_type rn;
      lc = '0;
      le = 2'd0;
      st = tst_pkg::ST_OK;
      rv = 1'b0;
      rn = rsp_ff;
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= '0;
         bank_ff  <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) flen_ff[i] <= '0;
         lcount_ff <= '0;
         lerr_ff   <= '0;
         lslot_ff  <= '0;
         lon_ff    <= 1'b0;
         scan_ff   <= '0;
         k_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff <= '{q_head.op, q_head.slot_type, q_head.slot_index,
                              id_m, cd_m, q_head.last_pair};
                  rn = '0;
                  case (q_head.op)
                     tst_pkg::OP_ALLOC: begin
                        if (q_head.slot_type == 2'd3) begin
                           rn.status = tst_pkg::ST_INVALID;
                           rv = 1'b1;
                        end else begin
                           scan_ff  <= '0;
                           state_ff <= S_ALLOC;
                        end
                     end
                     tst_pkg::OP_FREE: begin
                        if (!slot_ok || !busy_ff[s]) begin
                           rn.status = tst_pkg::ST_INVALID;
                        end else begin
                           busy_ff[s] <= 1'b0;
                           flen_ff[s] <= '0;
                           if (lon_ff && lslot_ff == s) begin
                              lon_ff <= 1'b0; lcount_ff <= '0; lerr_ff <= '0; lslot_ff <= '0;
                           end
                        end
                        rv = 1'b1;
                     end
                     tst_pkg::OP_PAIR: begin
                        if (!filt_ok) begin
                           lon_ff <= 1'b0; lcount_ff <= '0; lerr_ff <= '0; lslot_ff <= '0;
                           rn.status = tst_pkg::ST_INVALID;
                        end else begin
                           lc = (lon_ff && lslot_ff == s) ? lcount_ff : '0;
                           le = (lon_ff && lslot_ff == s) ? lerr_ff : 2'd0;
                           st = tst_pkg::ST_OK;
                           if (id_m > idw_m || cd_m > cdw_m) begin
                              if (le == 2'd0) le = tst_pkg::ST_INVALID;
                              st = tst_pkg::ST_INVALID;
                           end else if (lc >= LW'(MAX_PAIRS)) begin
                              if (le == 2'd0) le = tst_pkg::ST_TOO_MANY;
                              st = tst_pkg::ST_TOO_MANY;
                           end else begin
                              lc = lc + LW'(1);
                           end
                           if (q_head.last_pair) begin
                              st = le;
                              if (le == 2'd0) begin
                                 bank_ff[s] <= !bank_ff[s];
                                 flen_ff[s] <= lc;
                              end
                              lon_ff <= 1'b0; lcount_ff <= '0; lerr_ff <= '0; lslot_ff <= '0;
                           end else begin
                              lon_ff <= 1'b1; lcount_ff <= lc; lerr_ff <= le; lslot_ff <= s;
                           end
                           rn.status = st;
                        end
                        rv = 1'b1;
                     end
                     tst_pkg::OP_CLEAR: begin
                        if (!filt_ok) rn.status = tst_pkg::ST_INVALID;
                        else flen_ff[s] <= '0;
                        if (lon_ff && (!filt_ok || lslot_ff == s)) begin
                           lon_ff <= 1'b0; lcount_ff <= '0; lerr_ff <= '0; lslot_ff <= '0;
                        end
                        rv = 1'b1;
                     end
                     tst_pkg::OP_CHECK: begin
                        if (!filt_ok) begin
                           rn.status = tst_pkg::ST_INVALID;
                           rv = 1'b1;
                        end else begin
                           k_ff <= '0;
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        rn.status = tst_pkg::ST_INVALID;
                        rv = 1'b1;
                     end
                  endcase
               end
            end
            // one slot per cycle, lowest first
            S_ALLOC: begin
               if (32'(scan_ff) >= MAX_SLOTS) begin
                  rn.status = tst_pkg::ST_NO_FREE;
                  rv = 1'b1;
                  state_ff <= S_IDLE;
               end else if (!busy_ff[scan_s] && scan_type == cur_ff.slot_type) begin
                  busy_ff[scan_s] <= 1'b1;
                  flen_ff[scan_s] <= '0;
                  if (lon_ff && lslot_ff == scan_s) begin
                     lon_ff <= 1'b0; lcount_ff <= '0; lerr_ff <= '0; lslot_ff <= '0;
                  end
                  rn.granted_slot = 5'(scan_ff);
                  rv = 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            // pair scan: issue read, wait, compare
            S_READ: begin
               if (k_ff >= flen_ff[cs]) begin
                  rv = 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: state_ff <= S_CMP;
            S_CMP: begin
               if (hit) begin
                  rn.match = 1'b1;
                  rv = 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  k_ff <= k_ff + LW'(1);
                  state_ff <= S_READ;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         rsp_valid_ff <= rv;
         rsp_ff       <= rn;
      end
   end
endmodule

>>> src/tst_csr.sv
// apb-style configuration registers
// depends on tst_pkg
module tst_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output tst_pkg::cfg_type cfg
);
   tst_pkg::cfg_type cfg_ff;
   logic [2:0] idx;
   assign idx    = paddr[4:2];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{6'd0, 6'd0, 6'd0, 16'hFFFF, 16'hFFFF};
      end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
         case (idx)
            tst_pkg::REG_FIRST:  cfg_ff.first_count  <= pwdata[5:0];
            tst_pkg::REG_SECOND: cfg_ff.second_count <= pwdata[5:0];
            tst_pkg::REG_THIRD:  cfg_ff.third_count  <= pwdata[5:0];
            tst_pkg::REG_IDW:    cfg_ff.id_wildcard  <= pwdata[15:0];
            tst_pkg::REG_CDW:    cfg_ff.cd_wildcard  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (idx)
         tst_pkg::REG_FIRST:  prdata = {26'd0, cfg_ff.first_count};
         tst_pkg::REG_SECOND: prdata = {26'd0, cfg_ff.second_count};
         tst_pkg::REG_THIRD:  prdata = {26'd0, cfg_ff.third_count};
         tst_pkg::REG_IDW:    prdata = {16'd0, cfg_ff.id_wildcard};
         tst_pkg::REG_CDW:    prdata = {16'd0, cfg_ff.cd_wildcard};
         default:             prdata = 32'd0;
      endcase
   end
endmodule
